FILE: hw/rtl/mpre_pkg.sv
// Shared types, constants and mask table for the masked pixel run-length encoder.
`default_nettype none

package mpre_pkg;

    // Queue between the classifying front end and the output stage.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Longest run counted before a new run is forced.
    localparam logic [7:0] MaxRepeats = 8'hFF;

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_LEVEL = 1'b0;
    localparam t_cfg_index CFG_ALPHA = 1'b1;

    // One encoded run word, first field in the highest bits.
    typedef struct packed {
        logic       frame_end;
        logic [7:0] repeat_count;
        logic [7:0] run_blue;
        logic [7:0] run_green;
        logic [7:0] run_red;
    } t_run_word;

    // Words written by the front end in one cycle; w1 is only used with w0.
    typedef struct packed {
        logic      wr0;
        logic      wr1;
        t_run_word w0;
        t_run_word w1;
    } t_push;

    // Head of the queue as seen by the output stage.
    typedef struct packed {
        logic      valid;
        t_run_word word;
    } t_q_head;

    // Compare mask for a level, pixel packed red in the low byte, alpha on top.
    function automatic logic [31:0] level_mask(input logic [2:0] level,
                                               input logic alpha_en);
        logic [31:0] m;
        case (level)
            3'd0:    m = 32'hFFFF_FFFF;
            3'd1:    m = 32'hFFFE_FFFE;
            3'd2:    m = 32'hFFFC_FEFC;
            3'd3:    m = 32'hFFF8_FCF8;
            3'd4:    m = 32'hFFF0_F8F0;
            3'd5:    m = 32'hFFE0_F0E0;
            // Levels above five fall back to the level one mask.
            default: m = 32'hFFFE_FFFE;
        endcase
        if (!alpha_en) begin
            m[31:24] = 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpre_front.sv
// Front end: accepts pixels, keeps the open run and classifies each pixel into run words.
`default_nettype none

module mpre_front
    import mpre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire t_cfg_index  i_cfg_addr,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire logic [31:0] i_pixel,
    input  wire logic        i_last,
    output t_push            o_push
);

    logic [2:0]  r_level;
    logic        r_alpha_en;
    logic        r_open;
    logic [31:0] r_pix;
    logic [7:0]  r_rep;

    logic        n_open;
    logic [31:0] n_pix;
    logic [7:0]  n_rep;

    logic [31:0] mask;
    logic [31:0] pix;
    logic        match;
    t_run_word   old_word;
    t_run_word   last_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= 3'd0;
            r_alpha_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEVEL: r_level    <= i_cfg_wdata;
                CFG_ALPHA: r_alpha_en <= i_cfg_wdata[0];
                default:   r_level    <= r_level;
            endcase
        end
    end

    // Masked compare against the run's first pixel.
    always_comb begin
        mask  = level_mask(r_level, r_alpha_en);
        pix   = r_alpha_en ? i_pixel : {8'h00, i_pixel[23:0]};
        match = r_open && ((r_pix & mask) == (pix & mask)) && (r_rep != MaxRepeats);
    end

    // Next run state and the words this pixel writes.
    always_comb begin
        old_word = '{frame_end: 1'b0, repeat_count: r_rep, run_blue: r_pix[23:16],
                     run_green: r_pix[15:8], run_red: r_pix[7:0]};
        if (match) begin
            n_open = 1'b1;
            n_pix  = r_pix;
            n_rep  = r_rep + 8'd1;
        end else begin
            n_open = 1'b1;
            n_pix  = pix;
            n_rep  = 8'd0;
        end
        last_word = '{frame_end: 1'b1, repeat_count: n_rep, run_blue: n_pix[23:16],
                      run_green: n_pix[15:8], run_red: n_pix[7:0]};

        o_push = '0;
        if (i_accept) begin
            if (!match && r_open) begin
                o_push.wr0 = 1'b1;
                o_push.w0  = old_word;
                o_push.wr1 = i_last;
                o_push.w1  = last_word;
            end else begin
                o_push.wr0 = i_last;
                o_push.w0  = last_word;
            end
        end

        // End of frame closes the run.
        if (i_last) begin
            n_open = 1'b0;
            n_pix  = 32'd0;
            n_rep  = 8'd0;
        end
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pix  <= 32'd0;
            r_rep  <= 8'd0;
        end else if (i_accept) begin
            r_open <= n_open;
            r_pix  <= n_pix;
            r_rep  <= n_rep;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mpre_queue.sv
// Short queue of run words: two writes and one read per cycle.
`default_nettype none

module mpre_queue
    import mpre_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output t_q_head    o_head,
    output logic       o_room2
);

    t_run_word              r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wp;
    logic [QueuePtrW-1:0]   r_rp;
    logic [QueueCntW-1:0]   r_count;

    logic [QueuePtrW-1:0]   wp1;
    logic [QueueCntW-1:0]   n_push;

    always_comb begin
        wp1          = r_wp + QueuePtrW'(1);
        n_push       = QueueCntW'(i_push.wr0) + QueueCntW'(i_push.wr1);
        o_head.valid = (r_count != '0);
        o_head.word  = r_mem[r_rp];
        // Room for the worst case of two words from one pixel.
        o_room2      = (r_count <= QueueCntW'(QueueDepth - 2));
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wp] <= i_push.w0;
        end
        if (i_push.wr1) begin
            r_mem[wp1] <= i_push.w1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QueuePtrW'(n_push);
            r_rp    <= r_rp + QueuePtrW'(i_pop);
            r_count <= r_count + n_push - QueueCntW'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mpre_back.sv
// Output stage: moves run words from the queue into the output register.
`default_nettype none

module mpre_back
    import mpre_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_pop,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output t_run_word    o_word
);

    logic      r_valid;
    t_run_word r_word;

    // Load a new word whenever the register is empty or being taken.
    assign o_pop = i_head.valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_tready) begin
            r_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head.word;
        end
    end

    assign o_tvalid = r_valid;
    assign o_word   = r_word;

endmodule

`default_nettype wire

FILE: hw/rtl/masked_pixel_run_length_encoder.sv
// Top level of the masked pixel run-length encoder.
// The block takes one pixel word per clock while its queue has room for two words and
// turns runs of pixels that match under the level's mask into run words (first pixel's
// RGB and a repeat count of up to 255). A pixel is classified in the cycle it is
// accepted; the words it produces go into a four-entry queue and leave through a
// registered output, one word per cycle while the output side is ready. With the output
// side ready the block sustains one pixel per cycle; a pixel that both breaks a run and
// ends the frame writes two words, and the single output port then sets the pace.
// Configuration must be written only while the block is idle; the block has no check.
`default_nettype none

module masked_pixel_run_length_encoder
    import mpre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire t_cfg_index  i_cfg_addr,
    input  wire logic [2:0]  i_cfg_wdata,
    // Pixel input.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  wire logic        s_axis_tlast,   // frame_last
    // Run word output.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // run_red, run_green, run_blue, repeat_count
    output logic             m_axis_tlast    // frame_end
);

    t_push     push;
    t_q_head   head;
    logic      pop;
    logic      room2;
    logic      accept;
    t_run_word out_word;

    assign s_axis_tready = room2;
    assign accept        = s_axis_tvalid && room2;

    mpre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_pixel     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (push)
    );

    mpre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_room2 (room2)
    );

    mpre_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_word   (out_word)
    );

    assign m_axis_tdata = {out_word.repeat_count, out_word.run_blue,
                           out_word.run_green, out_word.run_red};
    assign m_axis_tlast = out_word.frame_end;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the masked pixel run-length encoder, with an in-line run predictor.
`default_nettype none

module testbench;
    import mpre_pkg::*;

    localparam int CycleLimit  = 100000;
    localparam int DrainCycles = 4;
    localparam int HoldCycles  = 400;
    localparam int PhaseCount  = 10;
    localparam int PhasePixels = 150;
    localparam int ReportLimit = 40;

    // Predicts the run words of the encoder and checks the words that leave it.
    class run_scoreboard;
        logic [2:0]  level;
        logic        alpha_on;
        bit          run_open;
        logic [31:0] run_pix;
        logic [7:0]  run_reps;
        t_run_word   expected_words[$];
        int          errors;
        int          pixels_seen;
        int          words_checked;
        int          frames_closed;
        int          two_word_pixels;
        int          capped_runs;

        function new();
            level    = 3'd0;
            alpha_on = 1'b1;
            run_open = 1'b0;
            run_pix  = '0;
            run_reps = '0;
        endfunction

        // Compare mask: red and blue lose one more low bit per level, green lags one level.
        function logic [31:0] compare_mask();
            int          eff;
            int          g_shift;
            logic [7:0]  rb;
            logic [7:0]  g;
            eff = (level > 3'd5) ? 1 : int'(level);
            g_shift = (eff == 0) ? 0 : eff - 1;
            rb = 8'hFF << eff;
            g  = 8'hFF << g_shift;
            return {(alpha_on ? 8'hFF : 8'h00), rb, g, rb};
        endfunction

        function void set_reg(t_cfg_index idx, logic [2:0] val);
            if (idx == CFG_LEVEL) begin
                level = val;
            end else begin
                alpha_on = val[0];
            end
        endfunction

        function void push_run(logic closes_frame);
            t_run_word w;
            w.run_red      = run_pix[7:0];
            w.run_green    = run_pix[15:8];
            w.run_blue     = run_pix[23:16];
            w.repeat_count = run_reps;
            w.frame_end    = closes_frame;
            expected_words.push_back(w);
        endfunction

        // Works out the run words that one accepted pixel causes.
        function void note_pixel(logic [31:0] pix, logic last);
            logic [31:0] m;
            int          prior_words;
            m = compare_mask();
            prior_words = expected_words.size();
            pixels_seen++;
            if (!alpha_on) begin
                pix[31:24] = 8'h00;
            end
            if (run_open && ((run_pix & m) == (pix & m)) && run_reps != MaxRepeats) begin
                run_reps++;
            end else begin
                if (run_open) begin
                    if ((run_pix & m) == (pix & m)) begin
                        capped_runs++;
                    end
                    push_run(1'b0);
                end
                run_open = 1'b1;
                run_pix  = pix;
                run_reps = '0;
            end
            if (last) begin
                push_run(1'b1);
                run_open = 1'b0;
                run_pix  = '0;
                run_reps = '0;
            end
            if (expected_words.size() - prior_words == 2) begin
                two_word_pixels++;
            end
        endfunction

        function void report_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                if (errors <= ReportLimit) begin
                    $display("%0t: %s mismatch, expected %h, actual %h",
                             $time, name, exp_v, got_v);
                end
            end
        endfunction

        // Compares a word from the block with the oldest expected word.
        function void check_word(t_run_word got);
            t_run_word exp_w;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= ReportLimit) begin
                    $display("%0t: unexpected run word, expected none, actual %h",
                             $time, got);
                end
                return;
            end
            exp_w = expected_words.pop_front();
            words_checked++;
            if (got.frame_end === 1'b1) begin
                frames_closed++;
            end
            report_field("run_red", exp_w.run_red, got.run_red);
            report_field("run_green", exp_w.run_green, got.run_green);
            report_field("run_blue", exp_w.run_blue, got.run_blue);
            report_field("repeat_count", exp_w.repeat_count, got.repeat_count);
            report_field("frame_end", {7'd0, exp_w.frame_end}, {7'd0, got.frame_end});
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_addr;
    logic [2:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red, green, blue, alpha
    logic        s_axis_tlast;   // frame_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // run_red, run_green, run_blue, repeat_count
    logic        m_axis_tlast;   // frame_end

    run_scoreboard sb = new();
    int            idle_pct = 12;
    bit            hold_wanted = 1'b0;
    bit            hold_done = 1'b0;
    int            cycles = 0;

    logic [2:0] phase_level [PhaseCount] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
                                              3'd5, 3'd7, 3'd6, 3'd0, 3'd5};
    logic       phase_alpha [PhaseCount] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                              1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    masked_pixel_run_length_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run timed out after %0d cycles", cycles);
        $display("masked_pixel_run_length_encoder: mismatch");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Observe both handshakes at the clock edge, with values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_word({m_axis_tlast, m_axis_tdata});
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_pixel(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    function automatic logic [31:0] rgba(input logic [7:0] r, g, b, a);
        return {a, b, g, r};
    endfunction

    // A pixel that matches base under the current mask, with random masked-off bits.
    function automatic logic [31:0] near_pixel(input logic [31:0] base);
        logic [31:0] m;
        m = sb.compare_mask();
        return (base & m) | ($urandom & ~m);
    endfunction

    // Offers one pixel word and waits until the block takes it.
    task automatic send_pixel(input logic [31:0] pix, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Register write, only once every expected word has left the block.
    task automatic write_cfg(input t_cfg_index idx, input logic [2:0] val);
        s_axis_tvalid <= 1'b0;
        // Let the monitor note the last accepted pixel before looking at the queue.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // One random phase: mostly runs of near-matching pixels, some noise.
    task automatic run_phase(input int budget, input bit long_run);
        int          sent;
        int          len;
        logic [31:0] base;
        sent = 0;
        if (long_run) begin
            // Long enough to hit the repeat limit and start a fresh run.
            len  = $urandom_range(258, 300);
            base = $urandom;
            for (int i = 0; i < len; i++) begin
                send_pixel(near_pixel(base), (i == len - 1) && $urandom_range(0, 1));
            end
            sent += len;
        end
        while (sent < budget) begin
            base = $urandom;
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_pixel(near_pixel(base), $urandom_range(0, 19) == 0);
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_pixel($urandom, $urandom_range(0, 9) == 0);
                end
            end
            sent += len;
        end
    endtask

    // Main stimulus.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_LEVEL;
        i_cfg_wdata   <= 3'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Exact compare at reset settings: lone frame pixel, alpha break,
        // a breaking pixel that also ends the frame.
        send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
        repeat (3) send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
        send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'h7F), 1'b0);
        send_pixel(rgba(8'h00, 8'hFF, 8'h00, 8'hFF), 1'b1);
        send_pixel(rgba(8'h12, 8'h34, 8'h56, 8'h78), 1'b0);
        send_pixel(rgba(8'h13, 8'h34, 8'h56, 8'h78), 1'b1);

        // Level seven acts as level one; RGB mode ignores alpha.
        write_cfg(CFG_LEVEL, 3'd7);
        write_cfg(CFG_ALPHA, 3'd0);
        send_pixel(rgba(8'h10, 8'h20, 8'h30, 8'h40), 1'b0);
        send_pixel(rgba(8'h11, 8'h20, 8'h30, 8'hC5), 1'b0);
        send_pixel(rgba(8'h10, 8'h21, 8'h30, 8'h00), 1'b1);

        // Coarsest mask; switch to RGB mode while a run with alpha is open.
        write_cfg(CFG_LEVEL, 3'd5);
        write_cfg(CFG_ALPHA, 3'd1);
        send_pixel(rgba(8'hE0, 8'hF0, 8'hE0, 8'h80), 1'b0);
        send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'h80), 1'b0);
        send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'h81), 1'b0);
        write_cfg(CFG_ALPHA, 3'd0);
        send_pixel(rgba(8'hE5, 8'hF3, 8'hE7, 8'h11), 1'b0);
        send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00), 1'b1);

        // Level six acts as level one: green still compared exactly.
        write_cfg(CFG_LEVEL, 3'd6);
        write_cfg(CFG_ALPHA, 3'd1);
        send_pixel(rgba(8'h01, 8'h01, 8'h01, 8'h01), 1'b0);
        send_pixel(rgba(8'h00, 8'h01, 8'h00, 8'h01), 1'b0);
        send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h01), 1'b1);

        // Random phases across the level and alpha settings.
        for (int p = 0; p < PhaseCount; p++) begin
            write_cfg(CFG_LEVEL, phase_level[p]);
            write_cfg(CFG_ALPHA, {2'b00, phase_alpha[p]});
            if (p == 3) begin
                hold_wanted = 1'b1;
            end
            idle_pct = (p == 4) ? 0 : 12;
            run_phase(PhasePixels, (p == 1) || (p == 6));
        end
        idle_pct = 12;
        s_axis_tvalid <= 1'b0;

        // Drain, then keep watching for any stray word.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Encoded %0d pixels into %0d run words over %0d frames, all six mask levels",
                 sb.pixels_seen, sb.words_checked, sb.frames_closed);
        $display("with both alpha modes; %0d pixels gave two words, %0d runs hit the limit",
                 sb.two_word_pixels, sb.capped_runs);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("masked_pixel_run_length_encoder: match");
        end else begin
            $display("masked_pixel_run_length_encoder: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
